[design/dsf_pkg.sv]
// Shared types, constants and fixed-point helpers for the damped spring force block.
// Used by every module of the block; depends on nothing else.
package dsf_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FIFO_DEPTH   = 4;

  // Angle difference scaled to Q30, its biased width and the number of reduction steps
  localparam int ZW   = 63 - FRAC_BITS;
  localparam int RW   = ZW + 1;
  localparam int NRED = ZW - 32;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_JOINTS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_ONE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_TWO   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REF_ONE     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TWO     = 4'd7;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [63:0] Q30_GAIN    = 64'sd652032874;
  localparam logic [69:0]        MAG_CAP     = 70'd1 << 40;

  typedef struct packed {
    logic [63:0]        body_one_position;
    logic [63:0]        body_one_velocity;
    logic signed [31:0] body_one_spin;
    logic signed [31:0] body_one_angle;
    logic [63:0]        body_two_position;
    logic [63:0]        body_two_velocity;
    logic signed [31:0] body_two_spin;
    logic signed [31:0] body_two_angle;
  } item_t;

  typedef struct packed {
    logic [63:0]        force_vector;
    logic signed [31:0] torque_one;
    logic signed [31:0] torque_two;
    logic               coincident;
  } res_t;

  typedef struct packed {
    logic signed [31:0] stiffness;
    logic signed [31:0] damping;
    logic signed [31:0] rest_length;
    logic               use_joints;
    logic [63:0]        joint_one_offset;
    logic [63:0]        joint_two_offset;
    logic signed [31:0] ref_angle_one;
    logic signed [31:0] ref_angle_two;
  } cfg_t;

  // Anchor points, anchor velocities and rotated offsets handed from front to back
  typedef struct packed {
    logic signed [31:0] p1x, p1y, p2x, p2y;
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic signed [31:0] o1x, o1y, o2x, o2y;
    logic               joints;
  } q_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic [34:0] umag35(input logic signed [47:0] v);
    logic [47:0] u;
    u = v[47] ? 48'(-v) : 48'(v);
    return (u > 48'h7FFFFFFFF) ? 35'h7FFFFFFFF : 35'(u);
  endfunction

  // sign * min(trunc(|a|*|b| / 2^s), 2^40)
  function automatic logic signed [41:0] mulsh(input logic signed [47:0] a,
                                               input logic signed [47:0] b,
                                               input int s);
    logic [69:0] p;
    logic [69:0] r;
    logic        neg;
    neg = a[47] ^ b[47];
    p = 70'(umag35(a)) * 70'(umag35(b));
    r = p >> s;
    if (r > MAG_CAP) r = MAG_CAP;
    return neg ? -42'(r) : 42'(r);
  endfunction

endpackage

[design/dsf_front.sv]
// Front end: takes items, rotates both anchor offsets (angle reduction + CORDIC pipeline)
// and forms anchor points and velocities. Depends on dsf_pkg.
module dsf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dsf_pkg::item_t in_item,
  input  dsf_pkg::cfg_t  cfg,
  output logic          out_valid,
  output dsf_pkg::q_t    out_q
);
  import dsf_pkg::*;

  localparam int S_FOLD = NRED;
  localparam int S_COR  = NRED + 1;
  localparam int S_RND  = NRED + 1 + CORDIC_STEPS;
  localparam int S_ANC  = S_RND + 1;
  localparam int NF     = S_ANC + 1;

  typedef struct packed {
    logic signed [63:0] x, y;
    logic signed [33:0] z;
    logic               neg;
  } rot_t;

  typedef struct packed {
    item_t              item;
    logic [RW-1:0]      r1, r2;
    rot_t               c1, c2;
    logic signed [31:0] o1x, o1y, o2x, o2y;
    q_t                 q;
  } fr_t;

  fr_t  pipe [0:NF];
  logic vld  [0:NF];

  function automatic logic [RW-1:0] red_init(input logic signed [31:0] angle,
                                             input logic signed [31:0] ref_a);
    logic signed [32:0]   d;
    logic signed [ZW-1:0] z;
    d = 33'(angle) - 33'(ref_a);
    z = ZW'(d) <<< (30 - FRAC_BITS);
    return RW'(z) + (RW'(Q30_TWO_PI) << (ZW - 33));
  endfunction

  function automatic logic [RW-1:0] red_step(input logic [RW-1:0] r, input int j);
    logic [RW-1:0] m;
    m = RW'(Q30_TWO_PI) << j;
    return (r >= m) ? r - m : r;
  endfunction

  function automatic rot_t rot_init(input logic [RW-1:0] r, input logic [63:0] off);
    rot_t               o;
    logic signed [35:0] zs;
    zs = 36'(r[32:0]);
    if (zs > Q30_PI) zs = zs - Q30_TWO_PI;
    o.neg = 1'b0;
    // beyond a quarter turn, fold by pi and negate at the end
    if (zs > Q30_HALF_PI) begin
      zs = zs - Q30_PI;
      o.neg = 1'b1;
    end else if (zs < -Q30_HALF_PI) begin
      zs = zs + Q30_PI;
      o.neg = 1'b1;
    end
    o.z = 34'(zs);
    o.x = 64'($signed(off[63:32])) * Q30_GAIN;
    o.y = 64'($signed(off[31:0])) * Q30_GAIN;
    return o;
  endfunction

  function automatic rot_t rot_step(input rot_t a, input int t);
    rot_t               o;
    logic signed [63:0] xs, ys;
    xs = a.x >>> t;
    ys = a.y >>> t;
    o.neg = a.neg;
    if (!a.z[33]) begin
      o.x = a.x - ys;
      o.y = a.y + xs;
      o.z = a.z - atan_q30(t);
    end else begin
      o.x = a.x + ys;
      o.y = a.y - xs;
      o.z = a.z + atan_q30(t);
    end
    return o;
  endfunction

  function automatic logic signed [31:0] rnd(input logic signed [63:0] v, input logic neg,
                                             input logic en);
    logic signed [63:0] r;
    r = (v + 64'sd536870912) >>> 30;
    if (neg) r = -r;
    return en ? sat32(48'(r)) : '0;
  endfunction

  function automatic fr_t fstep(input fr_t f, input int i, input cfg_t c);
    fr_t o;
    o = f;
    if (i < S_FOLD) begin
      o.r1 = red_step(f.r1, NRED - 1 - i);
      o.r2 = red_step(f.r2, NRED - 1 - i);
    end else if (i == S_FOLD) begin
      o.c1 = rot_init(f.r1, c.joint_one_offset);
      o.c2 = rot_init(f.r2, c.joint_two_offset);
    end else if (i < S_RND) begin
      o.c1 = rot_step(f.c1, i - S_COR);
      o.c2 = rot_step(f.c2, i - S_COR);
    end else if (i == S_RND) begin
      o.o1x = rnd(f.c1.x, f.c1.neg, c.use_joints);
      o.o1y = rnd(f.c1.y, f.c1.neg, c.use_joints);
      o.o2x = rnd(f.c2.x, f.c2.neg, c.use_joints);
      o.o2y = rnd(f.c2.y, f.c2.neg, c.use_joints);
    end else begin
      o.q.p1x = sat32(48'($signed(f.item.body_one_position[63:32])) + 48'(f.o1x));
      o.q.p1y = sat32(48'($signed(f.item.body_one_position[31:0])) + 48'(f.o1y));
      o.q.p2x = sat32(48'($signed(f.item.body_two_position[63:32])) + 48'(f.o2x));
      o.q.p2y = sat32(48'($signed(f.item.body_two_position[31:0])) + 48'(f.o2y));
      // point velocity: v + spin x offset
      o.q.v1x = sat32(48'($signed(f.item.body_one_velocity[63:32]))
                - 48'(mulsh(48'(f.item.body_one_spin), 48'(f.o1y), FRAC_BITS)));
      o.q.v1y = sat32(48'($signed(f.item.body_one_velocity[31:0]))
                + 48'(mulsh(48'(f.item.body_one_spin), 48'(f.o1x), FRAC_BITS)));
      o.q.v2x = sat32(48'($signed(f.item.body_two_velocity[63:32]))
                - 48'(mulsh(48'(f.item.body_two_spin), 48'(f.o2y), FRAC_BITS)));
      o.q.v2y = sat32(48'($signed(f.item.body_two_velocity[31:0]))
                + 48'(mulsh(48'(f.item.body_two_spin), 48'(f.o2x), FRAC_BITS)));
      o.q.o1x = f.o1x;
      o.q.o1y = f.o1y;
      o.q.o2x = f.o2x;
      o.q.o2y = f.o2y;
      o.q.joints = c.use_joints;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    pipe[0].item <= in_item;
    pipe[0].r1   <= red_init(in_item.body_one_angle, cfg.ref_angle_one);
    pipe[0].r2   <= red_init(in_item.body_two_angle, cfg.ref_angle_two);
    for (int i = 0; i < NF; i++) pipe[i+1] <= fstep(pipe[i], i, cfg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NF; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 0; i < NF; i++) vld[i+1] <= vld[i];
    end
  end

  assign out_valid = vld[NF];
  assign out_q     = pipe[NF].q;

endmodule

[design/dsf_fifo.sv]
// Short queue between front and back ends.
// Depends on dsf_pkg (q_t, FIFO_DEPTH).
module dsf_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  dsf_pkg::q_t push_data,
  output logic        pop,
  output dsf_pkg::q_t pop_data
);
  import dsf_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  q_t            mem [FIFO_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] count;

  // back end never stalls: drain whenever something is queued
  assign pop      = (count != '0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + PW'(1);
      if (pop) rp <= rp + PW'(1);
      count <= count + CW'(push) - CW'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_occupancy: assert property (@(posedge clk) disable iff (rst) count <= CW'(1))
    else $error("queue holds more than one transfer");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    push && count == '0 |=> count == CW'(1))
    else $error("transfer into empty queue lost");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !push && pop |=> count == '0)
    else $error("queue did not drain");
`endif

endmodule

[design/dsf_back.sv]
// Back end: direction (normalise, integer root, divide), damping and spring force, torques.
// Depends on dsf_pkg.
module dsf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dsf_pkg::q_t   in_q,
  input  dsf_pkg::cfg_t cfg,
  output logic          out_valid,
  output dsf_pkg::res_t out_res
);
  import dsf_pkg::*;

  localparam int S_RSH = 0;
  localparam int S_NRM = 1;
  localparam int S_SQ  = 6;
  localparam int S_SRT = 7;
  localparam int S_DIV = S_SRT + 32;
  localparam int S_SGN = S_DIV + 31;
  localparam int S_F1  = S_SGN + 1;
  localparam int S_F2  = S_F1 + 1;
  localparam int S_F3  = S_F2 + 1;
  localparam int S_F4  = S_F3 + 1;
  localparam int S_F5  = S_F4 + 1;
  localparam int NB    = S_F5 + 2;

  typedef struct packed {
    logic signed [32:0] rx, ry, dvx, dvy;
    logic signed [31:0] o1x, o1y, o2x, o2y;
    logic               joints, coinc;
    logic signed [32:0] nx, ny;
    logic [32:0]        m;
    logic [63:0]        n, res;
    logic [62:0]        remx, remy;
    logic [30:0]        qx, qy;
    logic signed [31:0] dx, dy;
    logic signed [41:0] vxa, vya, lx, ly;
    logic signed [42:0] vax, ex, ey;
    logic signed [41:0] mx, my, skx, sky, cx, cy;
    logic signed [31:0] fx, fy, t1, t2;
  } bk_t;

  bk_t  pipe [0:NB];
  logic vld  [0:NB];

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic bk_t bstep(input bk_t b, input int i, input cfg_t c);
    bk_t                o;
    int                 t;
    logic [32:0]        ax, ay;
    logic signed [63:0] sx, sy;
    logic [63:0]        bit_v, trial;
    logic [62:0]        rxi, ryi, dsh;
    logic [30:0]        qxi, qyi;
    o = b;
    if (i == S_RSH) begin
      ax = abs33(b.rx);
      ay = abs33(b.ry);
      o.m  = (ax > ay) ? ax : ay;
      o.nx = b.rx;
      o.ny = b.ry;
      if (o.m >= 33'h80000000) begin
        o.nx = b.rx >>> 1;
        o.ny = b.ry >>> 1;
        o.m  = o.m >> 1;
      end
    end else if (i < S_SQ) begin
      // binary-weighted left normalisation: 16, 8, 4, 2, 1
      t = 16 >> (i - S_NRM);
      if (b.m < (33'd1 << (31 - t))) begin
        o.nx = b.nx <<< t;
        o.ny = b.ny <<< t;
        o.m  = b.m << t;
      end
    end else if (i == S_SQ) begin
      sx = 64'(b.nx);
      sy = 64'(b.ny);
      o.n   = $unsigned(sx * sx + sy * sy);
      o.res = '0;
    end else if (i < S_DIV) begin
      t = i - S_SRT;
      bit_v = 64'd1 << (62 - 2 * t);
      trial = b.res + bit_v;
      if (b.n >= trial) begin
        o.n   = b.n - trial;
        o.res = (b.res >> 1) + bit_v;
      end else begin
        o.res = b.res >> 1;
      end
    end else if (i < S_SGN) begin
      t = 30 - (i - S_DIV);
      if (i == S_DIV) begin
        rxi = 63'(abs33(b.nx)) << 30;
        ryi = 63'(abs33(b.ny)) << 30;
        qxi = '0;
        qyi = '0;
      end else begin
        rxi = b.remx;
        ryi = b.remy;
        qxi = b.qx;
        qyi = b.qy;
      end
      dsh = 63'(b.res[31:0]) << t;
      if (rxi >= dsh) begin
        rxi = rxi - dsh;
        qxi[t] = 1'b1;
      end
      if (ryi >= dsh) begin
        ryi = ryi - dsh;
        qyi[t] = 1'b1;
      end
      o.remx = rxi;
      o.remy = ryi;
      o.qx   = qxi;
      o.qy   = qyi;
    end else if (i == S_SGN) begin
      // quotient truncated toward zero; coincident anchors give no direction
      o.dx = b.coinc ? '0 : (b.nx[32] ? -32'(b.qx) : 32'(b.qx));
      o.dy = b.coinc ? '0 : (b.ny[32] ? -32'(b.qy) : 32'(b.qy));
    end else if (i == S_F1) begin
      o.vxa = mulsh(48'(b.dvx), 48'(b.dx), 30);
      o.vya = mulsh(48'(b.dvy), 48'(b.dy), 30);
      o.lx  = mulsh(48'(c.rest_length), 48'(b.dx), 30);
      o.ly  = mulsh(48'(c.rest_length), 48'(b.dy), 30);
    end else if (i == S_F2) begin
      o.vax = 43'(b.vxa) + 43'(b.vya);
      o.ex  = 43'(b.rx) - 43'(b.lx);
      o.ey  = 43'(b.ry) - 43'(b.ly);
    end else if (i == S_F3) begin
      o.mx  = mulsh(48'(b.vax), 48'(b.dx), 30);
      o.my  = mulsh(48'(b.vax), 48'(b.dy), 30);
      o.skx = mulsh(48'(c.stiffness), 48'(b.ex), FRAC_BITS);
      o.sky = mulsh(48'(c.stiffness), 48'(b.ey), FRAC_BITS);
    end else if (i == S_F4) begin
      o.cx = mulsh(48'(c.damping), 48'(b.mx), FRAC_BITS);
      o.cy = mulsh(48'(c.damping), 48'(b.my), FRAC_BITS);
    end else if (i == S_F5) begin
      o.fx = sat32(48'(b.skx) + 48'(b.cx));
      o.fy = sat32(48'(b.sky) + 48'(b.cy));
    end else begin
      o.t1 = b.joints ? sat32(48'(mulsh(48'(b.o1x), 48'(b.fy), FRAC_BITS))
                              - 48'(mulsh(48'(b.o1y), 48'(b.fx), FRAC_BITS))) : '0;
      o.t2 = b.joints ? sat32(48'(mulsh(48'(b.fx), 48'(b.o2y), FRAC_BITS))
                              - 48'(mulsh(48'(b.fy), 48'(b.o2x), FRAC_BITS))) : '0;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    pipe[0].rx     <= 33'(in_q.p2x) - 33'(in_q.p1x);
    pipe[0].ry     <= 33'(in_q.p2y) - 33'(in_q.p1y);
    pipe[0].dvx    <= 33'(in_q.v2x) - 33'(in_q.v1x);
    pipe[0].dvy    <= 33'(in_q.v2y) - 33'(in_q.v1y);
    pipe[0].coinc  <= (in_q.p2x == in_q.p1x) && (in_q.p2y == in_q.p1y);
    pipe[0].o1x    <= in_q.o1x;
    pipe[0].o1y    <= in_q.o1y;
    pipe[0].o2x    <= in_q.o2x;
    pipe[0].o2y    <= in_q.o2y;
    pipe[0].joints <= in_q.joints;
    for (int i = 0; i < NB; i++) pipe[i+1] <= bstep(pipe[i], i, cfg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NB; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 0; i < NB; i++) vld[i+1] <= vld[i];
    end
  end

  assign out_valid              = vld[NB];
  assign out_res.force_vector   = {pipe[NB].fx, pipe[NB].fy};
  assign out_res.torque_one     = pipe[NB].t1;
  assign out_res.torque_two     = pipe[NB].t2;
  assign out_res.coincident     = pipe[NB].coinc;

endmodule

[design/damped_spring_force_2d.sv]
// Damped spring force between two planar rigid bodies: top level with configuration registers.
// Depends on dsf_pkg, dsf_front, dsf_fifo and dsf_back.
//
// Use: an item (both body states) is transferred at a clock edge with start high and busy
// low. busy is high in reset and in the cycle after it, so one item can be taken every cycle.
// Each item gives one result, shown on result for exactly one cycle with done high; results
// come out in the order the items went in, and the receiver cannot hold them off.
// The front end runs NRED = 31 - FRAC_BITS angle reduction steps (FRAC_BITS = 16 for Q16.16)
// and then CORDIC_STEPS (16) CORDIC steps. Every stage is pipelined, so throughput is one
// item per cycle; the depth is set mainly by the 32-step square root and the 31-step
// divider in the back end.
// Configuration: cfg_we writes cfg_data to register cfg_index in that cycle (0 stiffness,
// 1 damping, 2 rest_length, 3 use_joints, 4/5 joint offsets, 6/7 reference angles); other
// indexes are ignored. Write only while no item is in flight.
// Reset (rst, synchronous) restores the register defaults and drops every item in flight.
module damped_spring_force_2d (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  dsf_pkg::item_t                     item,
  output logic                               busy,
  input  logic                               cfg_we,
  input  logic [dsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                        cfg_data,
  output logic                               done,
  output dsf_pkg::res_t                      result
);
  import dsf_pkg::*;

  cfg_t cfg;
  logic accept;
  logic f_valid, b_valid;
  q_t   f_q, b_q;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy                 <= 1'b1;
      cfg.stiffness        <= 32'sd65536;
      cfg.damping          <= '0;
      cfg.rest_length      <= 32'sd65536;
      cfg.use_joints       <= 1'b0;
      cfg.joint_one_offset <= '0;
      cfg.joint_two_offset <= '0;
      cfg.ref_angle_one    <= '0;
      cfg.ref_angle_two    <= '0;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STIFFNESS:   cfg.stiffness        <= cfg_data[31:0];
          REG_DAMPING:     cfg.damping          <= cfg_data[31:0];
          REG_REST_LENGTH: cfg.rest_length      <= cfg_data[31:0];
          REG_USE_JOINTS:  cfg.use_joints       <= cfg_data[0];
          REG_JOINT_ONE:   cfg.joint_one_offset <= cfg_data;
          REG_JOINT_TWO:   cfg.joint_two_offset <= cfg_data;
          REG_REF_ONE:     cfg.ref_angle_one    <= cfg_data[31:0];
          REG_REF_TWO:     cfg.ref_angle_two    <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  dsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_item   (item),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out_q     (f_q)
  );

  dsf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_q),
    .pop       (b_valid),
    .pop_data  (b_q)
  );

  dsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_q      (b_q),
    .cfg       (cfg),
    .out_valid (done),
    .out_res   (result)
  );

endmodule

[verif/damped_spring_force_2d_test.sv]
// Self-checking testbench for damped_spring_force_2d: directed table plus random body states
// over several register settings, checked against a fixed-point spring force predictor.
// Depends on dsf_pkg and the damped_spring_force_2d RTL.
`timescale 1ns / 100ps

module damped_spring_force_2d_test;
  import dsf_pkg::*;

  localparam int  N_RANDOM   = 1430;
  localparam int  N_CALM     = 150;     // last transfers go with no idling
  localparam int  SETTLE     = 150;     // idle margin after the last result
  localparam int  CYCLE_CAP  = 400000;
  localparam int  N_SETTINGS = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd12;  // not decoded

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint CAP_40      = 64'sd1 << 40;

  logic        clk;
  logic        rst;
  logic        start;
  item_t       item;
  logic        busy;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic        done;
  res_t        result;

  damped_spring_force_2d i_dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  cfg_t   spring_cfg;
  res_t   force_due[$];
  bit     failed;
  int     cycles = 0;
  longint arctan_tab [0:24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint word(input logic [31:0] w);
    return longint'(signed'(w));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag_capped(input longint v);
    longint u;
    u = (v < 0) ? -v : v;
    return (u > 64'sh7FFFFFFFF) ? 64'sh7FFFFFFFF : u;
  endfunction

  // truncating fixed-point product, magnitude capped at 2^40
  function automatic longint fx_mul(input longint a, input longint b, input int s);
    logic [127:0] p;
    longint       r;
    p = 128'(mag_capped(a)) * 128'(mag_capped(b));
    p = p >> s;
    r = (p > 128'(CAP_40)) ? CAP_40 : longint'(p);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint root_floor(input logic [63:0] n);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  task automatic turn_offset(input logic [63:0] off, input longint ang, input longint base,
                             output longint ox, output longint oy);
    longint z, x, y, xs, ys;
    bit     flip;
    flip = 1'b0;
    z = (ang - base) * (64'sd1 << (30 - FRAC_BITS));
    z = z % TWO_PI_Q30;
    if (z > PI_Q30) z -= TWO_PI_Q30;
    if (z <= -PI_Q30) z += TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30; flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30; flip = 1'b1;
    end
    x = word(off[63:32]) * GAIN_Q30;
    y = word(off[31:0]) * GAIN_Q30;
    for (int i = 0; i < CORDIC_STEPS && i < 25; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_tab[i];
      end else begin
        x += ys; y -= xs; z += arctan_tab[i];
      end
    end
    x = (x + (64'sd1 << 29)) >>> 30;
    y = (y + (64'sd1 << 29)) >>> 30;
    if (flip) begin
      x = -x; y = -y;
    end
    ox = clamp32(x);
    oy = clamp32(y);
  endtask

  task automatic predict_spring(input item_t it, output res_t r);
    longint o1x, o1y, o2x, o2y, w1, w2;
    longint p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
    longint rx, ry, dx, dy, nx, ny, m, l, vax, fx, fy, t1, t2, k, c, len;
    bit     same;
    o1x = 0; o1y = 0; o2x = 0; o2y = 0; dx = 0; dy = 0; t1 = 0; t2 = 0;
    w1 = word(it.body_one_spin);
    w2 = word(it.body_two_spin);
    k = word(spring_cfg.stiffness);
    c = word(spring_cfg.damping);
    len = word(spring_cfg.rest_length);
    if (spring_cfg.use_joints) begin
      turn_offset(spring_cfg.joint_one_offset, word(it.body_one_angle),
                  word(spring_cfg.ref_angle_one), o1x, o1y);
      turn_offset(spring_cfg.joint_two_offset, word(it.body_two_angle),
                  word(spring_cfg.ref_angle_two), o2x, o2y);
    end
    p1x = clamp32(word(it.body_one_position[63:32]) + o1x);
    p1y = clamp32(word(it.body_one_position[31:0]) + o1y);
    p2x = clamp32(word(it.body_two_position[63:32]) + o2x);
    p2y = clamp32(word(it.body_two_position[31:0]) + o2y);
    v1x = clamp32(word(it.body_one_velocity[63:32]) - fx_mul(w1, o1y, FRAC_BITS));
    v1y = clamp32(word(it.body_one_velocity[31:0]) + fx_mul(w1, o1x, FRAC_BITS));
    v2x = clamp32(word(it.body_two_velocity[63:32]) - fx_mul(w2, o2y, FRAC_BITS));
    v2y = clamp32(word(it.body_two_velocity[31:0]) + fx_mul(w2, o2x, FRAC_BITS));
    rx = p2x - p1x;
    ry = p2y - p1y;
    same = (rx == 0) && (ry == 0);
    if (!same) begin
      nx = rx; ny = ry;
      m = (mag_capped(nx) > mag_capped(ny)) ? mag_capped(nx) : mag_capped(ny);
      while (m >= (64'sd1 << 31)) begin
        nx = nx >>> 1; ny = ny >>> 1; m = m >> 1;
      end
      while (m < (64'sd1 << 30)) begin
        nx = nx * 2; ny = ny * 2; m = m << 1;
      end
      l = root_floor(64'(nx * nx) + 64'(ny * ny));
      dx = (nx * (64'sd1 << 30)) / l;
      dy = (ny * (64'sd1 << 30)) / l;
    end
    vax = fx_mul(v2x - v1x, dx, 30) + fx_mul(v2y - v1y, dy, 30);
    fx = clamp32(fx_mul(k, rx - fx_mul(len, dx, 30), FRAC_BITS)
                 + fx_mul(c, fx_mul(vax, dx, 30), FRAC_BITS));
    fy = clamp32(fx_mul(k, ry - fx_mul(len, dy, 30), FRAC_BITS)
                 + fx_mul(c, fx_mul(vax, dy, 30), FRAC_BITS));
    if (spring_cfg.use_joints) begin
      t1 = clamp32(fx_mul(o1x, fy, FRAC_BITS) - fx_mul(o1y, fx, FRAC_BITS));
      t2 = clamp32(fx_mul(fx, o2y, FRAC_BITS) - fx_mul(fy, o2x, FRAC_BITS));
    end
    r.force_vector = {fx[31:0], fy[31:0]};
    r.torque_one   = t1[31:0];
    r.torque_two   = t2[31:0];
    r.coincident   = same;
  endtask

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (force_due.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, result);
        failed = 1'b1;
      end else begin
        want = force_due.pop_front();
        if (result.force_vector !== want.force_vector) begin
          $display("%0t: force_vector expected %h actual %h", $time,
                   want.force_vector, result.force_vector);
          failed = 1'b1;
        end
        if (result.torque_one !== want.torque_one) begin
          $display("%0t: torque_one expected %h actual %h", $time,
                   want.torque_one, result.torque_one);
          failed = 1'b1;
        end
        if (result.torque_two !== want.torque_two) begin
          $display("%0t: torque_two expected %h actual %h", $time,
                   want.torque_two, result.torque_two);
          failed = 1'b1;
        end
        if (result.coincident !== want.coincident) begin
          $display("%0t: coincident expected %b actual %b", $time,
                   want.coincident, result.coincident);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 32'($urandom_range(0, 32'h001FFFFF)) - 32'h00100000;
    if (sel < 8) return $urandom();
    if (sel == 9) return 32'($urandom_range(0, 511)) - 32'd256;
    case ($urandom_range(0, 3))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      default: return 32'h0;
    endcase
  endfunction

  function automatic item_t pick_item();
    item_t it;
    it = item_t'{{pick_word(), pick_word()}, {pick_word(), pick_word()}, pick_word(),
                 pick_word(), {pick_word(), pick_word()}, {pick_word(), pick_word()},
                 pick_word(), pick_word()};
    if ($urandom_range(0, 15) == 0) it.body_two_position = it.body_one_position;
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STIFFNESS:   spring_cfg.stiffness        = data[31:0];
      REG_DAMPING:     spring_cfg.damping          = data[31:0];
      REG_REST_LENGTH: spring_cfg.rest_length      = data[31:0];
      REG_USE_JOINTS:  spring_cfg.use_joints       = data[0];
      REG_JOINT_ONE:   spring_cfg.joint_one_offset = data;
      REG_JOINT_TWO:   spring_cfg.joint_two_offset = data;
      REG_REF_ONE:     spring_cfg.ref_angle_one    = data[31:0];
      REG_REF_TWO:     spring_cfg.ref_angle_two    = data[31:0];
      default: ;
    endcase
  endtask

  // junk in the upper half checks that narrow registers drop it
  function automatic logic [63:0] junk_hi(input logic [31:0] v);
    return {$urandom(), v};
  endfunction

  task automatic apply_setting(input int n);
    case (n)
      0: begin
        write_reg(REG_STIFFNESS, junk_hi(32'h00020000));
        write_reg(REG_DAMPING, junk_hi(32'h00008000));
        write_reg(REG_REST_LENGTH, junk_hi(32'h00018000));
        write_reg(REG_SPARE, {$urandom(), $urandom()});
      end
      1: begin
        write_reg(REG_USE_JOINTS, {$urandom(), 32'($urandom()) | 32'd1});
        write_reg(REG_DAMPING, junk_hi(32'hFFFFC000));
        write_reg(REG_JOINT_ONE, {32'h00010000, 32'hFFFF8000});
        write_reg(REG_JOINT_TWO, {32'hFFFE0000, 32'h00004000});
        write_reg(REG_REF_ONE, junk_hi(pick_word()));
        write_reg(REG_REF_TWO, junk_hi(pick_word()));
      end
      2: begin
        write_reg(REG_STIFFNESS, junk_hi(32'h7FFFFFFF));
        write_reg(REG_DAMPING, junk_hi(32'h80000000));
        write_reg(REG_REST_LENGTH, junk_hi(32'h7FFFFFFF));
        write_reg(REG_JOINT_ONE, 64'h7FFFFFFF_80000000);
        write_reg(REG_JOINT_TWO, 64'h80000000_7FFFFFFF);
        write_reg(REG_REF_ONE, junk_hi(32'h80000000));
        write_reg(REG_REF_TWO, junk_hi(32'h7FFFFFFF));
      end
      3: begin
        write_reg(REG_STIFFNESS, junk_hi(32'h80000000));
        write_reg(REG_DAMPING, junk_hi(32'h7FFFFFFF));
        write_reg(REG_REST_LENGTH, junk_hi(32'h80000000));
        write_reg(REG_JOINT_ONE, {pick_word(), pick_word()});
        write_reg(REG_JOINT_TWO, {pick_word(), pick_word()});
        write_reg(REG_REF_ONE, 64'd0);
        write_reg(REG_REF_TWO, 64'd0);
      end
      4: begin
        write_reg(REG_USE_JOINTS, {$urandom(), 32'($urandom()) & ~32'd1});
        write_reg(REG_STIFFNESS, junk_hi(32'h00010000));
        write_reg(REG_DAMPING, junk_hi(32'h00008000));
        write_reg(REG_REST_LENGTH, junk_hi(32'h0));
        write_reg(REG_JOINT_ONE, {$urandom(), $urandom()});
      end
      default: begin
        write_reg(REG_USE_JOINTS, 64'd1);
        write_reg(REG_STIFFNESS, junk_hi(pick_word()));
        write_reg(REG_DAMPING, junk_hi(pick_word()));
        write_reg(REG_REST_LENGTH, junk_hi(pick_word()));
        write_reg(REG_JOINT_ONE, {$urandom(), $urandom()});
        write_reg(REG_JOINT_TWO, {$urandom(), $urandom()});
        write_reg(REG_REF_ONE, junk_hi($urandom()));
        write_reg(REG_REF_TWO, junk_hi($urandom()));
      end
    endcase
  endtask

  // one transfer; start stays high when the next item follows straight on
  task automatic send_item(input item_t it, input bit typed, input res_t fixed, input bit calm);
    res_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (typed) begin
      r = fixed;
    end else begin
      predict_spring(it, r);
    end
    force_due.push_back(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (force_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  typedef struct {
    item_t stim;
    bit    typed;
    res_t  want;
  } row_t;

  initial begin
    row_t  rows[$];
    row_t  rw;
    res_t  none;
    int    per_setting;
    int    sent;
    none = '0;
    failed = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    spring_cfg = '0;
    spring_cfg.stiffness = 32'h00010000;
    spring_cfg.rest_length = 32'h00010000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table, reset register values
    rw.stim = '0; rw.typed = 1; rw.want = '{64'd0, 32'd0, 32'd0, 1'b1};
    rows.push_back(rw);
    rw.stim = '1; rw.typed = 1; rw.want = '{64'd0, 32'd0, 32'd0, 1'b1};
    rows.push_back(rw);
    // stretch exactly at rest length along x
    rw.stim = '0; rw.stim.body_two_position = {32'h00010000, 32'h0};
    rw.typed = 1; rw.want = '{64'd0, 32'd0, 32'd0, 1'b0};
    rows.push_back(rw);
    // one unit beyond rest along y
    rw.stim = '0; rw.stim.body_two_position = {32'h0, 32'h00020000};
    rw.typed = 1; rw.want = '{{32'h0, 32'h00010000}, 32'd0, 32'd0, 1'b0};
    rows.push_back(rw);
    rw.typed = 0; rw.want = none;
    rw.stim = '0;
    rw.stim.body_one_position = 64'h80000000_80000000;
    rw.stim.body_two_position = 64'h7FFFFFFF_7FFFFFFF;
    rows.push_back(rw);
    rw.stim.body_one_position = 64'h7FFFFFFF_80000000;
    rw.stim.body_two_position = 64'h80000000_7FFFFFFF;
    rw.stim.body_one_velocity = 64'h7FFFFFFF_7FFFFFFF;
    rw.stim.body_two_velocity = 64'h80000000_80000000;
    rw.stim.body_one_spin = 32'sh7FFFFFFF;
    rw.stim.body_two_spin = 32'sh80000000;
    rw.stim.body_one_angle = 32'sh80000000;
    rw.stim.body_two_angle = 32'sh7FFFFFFF;
    rows.push_back(rw);
    // tiny separation, one LSB
    rw.stim = '0; rw.stim.body_two_position = 64'h00000000_00000001;
    rows.push_back(rw);
    rw.stim = '0; rw.stim.body_two_position = 64'hFFFFFFFF_FFFFFFFF;
    rows.push_back(rw);
    for (int i = 0; i < 8; i++) begin
      rw.stim = pick_item();
      rows.push_back(rw);
    end
    foreach (rows[i]) send_item(rows[i].stim, rows[i].typed, rows[i].want, 1'b0);
    drain();

    // directed again with joints, rotated anchors at extreme angles
    write_reg(REG_USE_JOINTS, 64'd1);
    write_reg(REG_JOINT_ONE, {32'h00010000, 32'h0});
    write_reg(REG_JOINT_TWO, {32'h0, 32'hFFFF0000});
    rw.typed = 0;
    for (int i = 0; i < 6; i++) begin
      rw.stim = '0;
      rw.stim.body_two_position = {32'h00030000, 32'h0};
      rw.stim.body_one_spin = 32'sh00010000;
      rw.stim.body_two_spin = -32'sh00020000;
      rw.stim.body_one_angle = (i == 0) ? 32'sh7FFFFFFF : (i == 1) ? 32'sh80000000 :
                               32'(i * 32'sh0001A000);
      rw.stim.body_two_angle = 32'sh0003243F - 32'(i);  // about pi
      send_item(rw.stim, 1'b0, none, 1'b0);
    end
    drain();

    per_setting = N_RANDOM / N_SETTINGS;
    sent = 0;
    for (int s = 0; s < N_SETTINGS; s++) begin
      apply_setting(s);
      for (int i = 0; i < per_setting; i++) begin
        send_item(pick_item(), 1'b0, none, sent >= N_RANDOM - N_CALM);
        sent++;
      end
      drain();
    end

    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
